// ----- hw/rtl/mer_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, types and the log2 table generator of the MER meter.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int SW      = 16;   // sample width
  localparam int CW      = 16;   // config register width
  localparam int FRAC    = 16;   // fraction bits of the averages
  localparam int SIGP_W  = 32;
  localparam int ERRP_W  = 33;
  localparam int SACC_W  = 48;
  localparam int EACC_W  = 49;
  localparam int LOG_W   = 22;   // log2 in Q6.16
  localparam int MER_W   = 16;
  localparam logic [17:0] DB_PER_OCT = 18'd197283;  // 10*log10(2), Q.16

  typedef struct packed {
    logic [SIGP_W-1:0] sig;
    logic [ERRP_W-1:0] err;
  } pwr_t;

  typedef enum logic {
    CFG_ALPHA = 1'b0,
    CFG_FLOOR = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_SUM, BK_DIV, BK_START, BK_WAIT, BK_SCALE, BK_OUT
  } bk_state_t;

  typedef enum logic [2:0] {
    LG_IDLE, LG_NORM, LG_MUL, LG_SUM, LG_DONE
  } lg_state_t;

  // log2(1 + k/2^lb) in Q.16 by repeated squaring in Q1.30
  function automatic logic [16:0] log_entry(input int k, input int lb);
    logic [63:0] m;
    logic [16:0] r;
    m = 64'((64'd1 << lb) + 64'(k)) << (30 - lb);
    r = '0;
    if (k >= (1 << lb)) begin
      r = 17'h10000;
    end else begin
      for (int b = 0; b < FRAC; b++) begin
        m = (m * m) >> 30;
        r = {r[15:0], 1'b0};
        if (m >= 64'h8000_0000) begin
          r[0] = 1'b1;
          m = m >> 1;
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mer_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_front
// Reference power and error power of one incoming sample.
// ----------------------------------------------------------------------------
module mer_front import mer_pkg::*; (
  input  logic signed [SW-1:0] rx_i,
  input  logic signed [SW-1:0] rx_q,
  input  logic signed [SW-1:0] ref_i,
  input  logic signed [SW-1:0] ref_q,
  output pwr_t                 pwr
);

  logic signed [2*SW-1:0] si2, sq2;
  logic signed [SW:0]     di, dq;
  logic signed [2*SW+1:0] ei2, eq2;

  always_comb begin
    si2 = ref_i * ref_i;
    sq2 = ref_q * ref_q;
    di  = {rx_i[SW-1], rx_i} - {ref_i[SW-1], ref_i};
    dq  = {rx_q[SW-1], rx_q} - {ref_q[SW-1], ref_q};
    ei2 = di * di;
    eq2 = dq * dq;
    pwr.sig = SIGP_W'($unsigned(si2)) + SIGP_W'($unsigned(sq2));
    pwr.err = ERRP_W'($unsigned(ei2)) + ERRP_W'($unsigned(eq2));
  end

endmodule

// ----- hw/rtl/mer_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_fifo
// Short queue of power pairs between the front and the back.
// ----------------------------------------------------------------------------
module mer_fifo import mer_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  pwr_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output pwr_t rdata
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  pwr_t          mem [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= wdata;
  end

endmodule

// ----- hw/rtl/mer_log2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_log2
// Bit-serial normalizer and table interpolation: log2 of a 49-bit word, Q.16.
// ----------------------------------------------------------------------------
module mer_log2 import mer_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [EACC_W-1:0] x,
  output logic              done,
  output logic [LOG_W-1:0]  lval
);

  localparam int LB = $clog2(DEPTH);
  localparam int SH = 30 - LB;
  localparam int EB = $clog2(EACC_W);

  lg_state_t         state_r, state_nxt;
  logic [EACC_W-1:0] w_r;
  logic [EB-1:0]     e_r;
  logic [16:0]       t0_r, t1_r;
  logic [SH-1:0]     rem_r;
  logic [SH+16:0]    prod_r;
  logic [LOG_W-1:0]  l_r;
  logic [16:0]       tab [DEPTH+1];
  logic [LB:0]       idx;

  for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
    assign tab[k] = log_entry(k, LB);
  end

  assign idx  = {1'b0, w_r[EACC_W-2 -: LB]};
  assign done = (state_r == LG_DONE);
  assign lval = l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= LG_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LG_IDLE, LG_DONE: if (start) state_nxt = LG_NORM;
      LG_NORM: if (w_r[EACC_W-1] || e_r == '0) state_nxt = LG_MUL;
      LG_MUL:  state_nxt = LG_SUM;
      LG_SUM:  state_nxt = LG_DONE;
      default: state_nxt = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      LG_IDLE, LG_DONE: begin
        if (start) begin
          w_r <= x;
          e_r <= EB'(EACC_W - 1);
        end
      end
      LG_NORM: begin
        if (w_r[EACC_W-1] || e_r == '0) begin
          t0_r  <= tab[idx];
          t1_r  <= tab[idx + 1'b1];
          rem_r <= w_r[EACC_W-2-LB -: SH];
        end else begin
          w_r <= {w_r[EACC_W-2:0], 1'b0};
          e_r <= e_r - 1'b1;
        end
      end
      LG_MUL: prod_r <= (t1_r - t0_r) * rem_r;
      LG_SUM: l_r <= LOG_W'({e_r, 16'b0}) + LOG_W'(t0_r) + LOG_W'(prod_r >> SH);
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/mer_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_back
// Average update, floored ratio in the log domain and dB scaling.
// ----------------------------------------------------------------------------
module mer_back import mer_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_pop,
  input  pwr_t              q_data,
  input  logic [CW-1:0]     alpha,
  input  logic [CW-1:0]     err_floor,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [MER_W-1:0]  mer_db,
  output logic [31:0]       sig_avg,
  output logic [32:0]       err_avg
);

  bk_state_t         state_r, state_nxt;
  pwr_t              item_r;
  logic [CW-1:0]     a_r;
  logic [CW:0]       b_r;
  logic [SACC_W-1:0] sacc_r;
  logic [EACC_W-1:0] eacc_r, div_r;
  logic [38:0]       sph_r;
  logic [39:0]       sah_r, eph_r;
  logic [40:0]       spl_r, epl_r, eah_r;
  logic [41:0]       sal_r, eal_r;
  logic signed [41:0] mprod_r;
  logic              out_valid_r;
  logic [MER_W-1:0]  mer_r;
  logic [31:0]       sig_avg_r;
  logic [32:0]       err_avg_r;
  logic [SACC_W-1:0] p_sig;
  logic [EACC_W-1:0] p_err;
  logic [40:0]       shi;
  logic [42:0]       slo, elo;
  logic [41:0]       ehi;
  logic [CW-1:0]     flr16;
  logic [EACC_W-1:0] flr;
  logic              log_start, sig_done, div_done;
  logic [LOG_W-1:0]  l_sig, l_div;
  logic signed [LOG_W:0] d;
  logic signed [41:0] rnd;
  logic signed [17:0] mq;
  logic [MER_W-1:0]  mer_sat;

  assign q_pop     = (state_r == BK_IDLE) && !q_empty && !out_valid_r;
  assign log_start = (state_r == BK_START);
  assign out_empty = !out_valid_r;
  assign mer_db    = mer_r;
  assign sig_avg   = sig_avg_r;
  assign err_avg   = err_avg_r;

  mer_log2 #(.DEPTH(DEPTH)) u_log_sig (
    .clk, .rst_n, .start(log_start), .x({1'b0, sacc_r}), .done(sig_done), .lval(l_sig)
  );
  mer_log2 #(.DEPTH(DEPTH)) u_log_div (
    .clk, .rst_n, .start(log_start), .x(div_r), .done(div_done), .lval(l_div)
  );

  always_comb begin
    p_sig = {item_r.sig, 16'b0};
    p_err = {item_r.err, 16'b0};
    shi   = 41'(sph_r) + 41'(sah_r);
    slo   = 43'(spl_r) + 43'(sal_r);
    ehi   = 42'(eph_r) + 42'(eah_r);
    elo   = 43'(epl_r) + 43'(eal_r);
    flr16 = (err_floor == '0) ? CW'(1) : err_floor;
    flr   = EACC_W'({flr16, 16'b0});
    d     = $signed({1'b0, l_sig}) - $signed({1'b0, l_div});
    rnd   = (mprod_r + 42'sd8388608) >>> 24;
    mq    = rnd[17:0];
    if (sacc_r == '0 || mq < -18'sd32768) mer_sat = 16'h8000;
    else if (mq > 18'sd32767)             mer_sat = 16'h7FFF;
    else                                  mer_sat = mq[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (q_pop) state_nxt = BK_MUL;
      BK_MUL:   state_nxt = BK_SUM;
      BK_SUM:   state_nxt = BK_DIV;
      BK_DIV:   state_nxt = BK_START;
      BK_START: state_nxt = BK_WAIT;
      BK_WAIT:  if (sig_done && div_done) state_nxt = BK_SCALE;
      BK_SCALE: state_nxt = BK_OUT;
      BK_OUT:   state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // averages and result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sacc_r      <= '0;
      eacc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == BK_SUM) begin
        sacc_r <= SACC_W'({shi, 9'b0}) + SACC_W'(slo >> 16);
        eacc_r <= EACC_W'({ehi, 9'b0}) + EACC_W'(elo >> 16);
      end
      if (state_r == BK_OUT)              out_valid_r <= 1'b1;
      else if (out_pop && out_valid_r)    out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          item_r <= q_data;
          a_r    <= alpha;
          b_r    <= 17'h10000 - (CW+1)'(alpha);
        end
      end
      BK_MUL: begin
        sph_r <= p_sig[47:25] * a_r;
        spl_r <= p_sig[24:0]  * a_r;
        sah_r <= sacc_r[47:25] * b_r;
        sal_r <= sacc_r[24:0]  * b_r;
        eph_r <= p_err[48:25] * a_r;
        epl_r <= p_err[24:0]  * a_r;
        eah_r <= eacc_r[48:25] * b_r;
        eal_r <= eacc_r[24:0]  * b_r;
      end
      BK_DIV:   div_r <= (eacc_r > flr) ? eacc_r : flr;
      BK_SCALE: mprod_r <= d * $signed({1'b0, DB_PER_OCT});
      BK_OUT: begin
        mer_r     <= mer_sat;
        sig_avg_r <= sacc_r[47:16];
        err_avg_r <= eacc_r[48:16];
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/modulation_error_ratio_meter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulation_error_ratio_meter_top
// MER meter: exponential averages of reference and error power, MER in dB.
//
//   channel  direction  handshake        payload
//   in_      input      in_push/in_full  rx_i rx_q ref_i ref_q (s16)
//   out_     output     out_empty/out_pop mer_db (s16 Q8.8), averages (u32/u33)
//   cfg_     input      cfg_we           cfg_index, cfg_data (16b)
//
// In the back end, the time from the queue read to the result register load
// is set by the bit-serial normalizer of the log2 units (one bit per cycle
// over 49 bits). While the queue is not full, the front takes an item every
// cycle into a 4-entry queue, so bursts of up to 4 items wait there while
// the back end works or the result stalls.
// Reset is synchronous, active low; averages reset to zero.
// ----------------------------------------------------------------------------
module modulation_error_ratio_meter_top import mer_pkg::*; #(
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [SW-1:0] in_rx_i,
  input  logic signed [SW-1:0] in_rx_q,
  input  logic signed [SW-1:0] in_ref_i,
  input  logic signed [SW-1:0] in_ref_q,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [15:0]  out_mer_db,
  output logic [31:0]         out_signal_power_avg,
  output logic [32:0]         out_error_power_avg,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CW-1:0]       cfg_data
);

  pwr_t          f_pwr, q_data;
  logic          q_push, q_pop, q_empty;
  logic [CW-1:0] alpha_r, floor_r;
  logic [15:0]   mer;

  assign q_push     = in_push && !in_full;
  assign out_mer_db = $signed(mer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 16'd656;
      floor_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ALPHA: alpha_r <= cfg_data;
        CFG_FLOOR: floor_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mer_front u_front (
    .rx_i(in_rx_i), .rx_q(in_rx_q), .ref_i(in_ref_i), .ref_q(in_ref_q), .pwr(f_pwr)
  );

  mer_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .wdata(f_pwr), .full(in_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_data)
  );

  mer_back #(.DEPTH(LOG_TABLE_DEPTH)) u_back (
    .clk, .rst_n, .q_empty, .q_pop, .q_data, .alpha(alpha_r), .err_floor(floor_r),
    .out_empty, .out_pop, .mer_db(mer), .sig_avg(out_signal_power_avg),
    .err_avg(out_error_power_avg)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue read while empty");

  a_full_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !q_empty) else $error("queue full and empty at once");

  a_result_leaves_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_empty) |-> $past(out_pop)) else $error("result dropped without pop");

endmodule

// ----- verif/mer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_checker
// Watches the sample, result and register ports of the MER meter, predicts
// each result from its own copy of the averages and registers, and compares
// the results in order as they are popped.
// ----------------------------------------------------------------------------
module mer_checker import mer_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic signed [SW-1:0] in_rx_i,
  input  logic signed [SW-1:0] in_rx_q,
  input  logic signed [SW-1:0] in_ref_i,
  input  logic signed [SW-1:0] in_ref_q,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic signed [15:0]   out_mer_db,
  input  logic [31:0]          out_signal_power_avg,
  input  logic [32:0]          out_error_power_avg,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CW-1:0]        cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int LUT_BITS = 8;
  localparam int LUT_SH   = 30 - LUT_BITS;

  typedef struct {
    logic signed [15:0] mer;
    logic [31:0]        sig;
    logic [32:0]        err;
  } mer_result_t;

  mer_result_t        result_q[$];
  logic [16:0]        log2_lut [0:(1 << LUT_BITS)];
  logic [15:0]        alpha_reg;
  logic [15:0]        floor_reg;
  logic [SACC_W-1:0]  sig_avg;
  logic [EACC_W-1:0]  err_avg;

  // log2(1 + k/256) in Q.16: square the mantissa, emit a bit on each overflow
  initial begin
    logic [63:0] m;
    logic [16:0] bits;
    for (int k = 0; k < (1 << LUT_BITS); k++) begin
      m = 64'((1 << LUT_BITS) + k) << LUT_SH;
      bits = '0;
      for (int b = 0; b < 16; b++) begin
        m = (m * m) >> 30;
        bits = bits << 1;
        if (m >= 64'h8000_0000) begin
          bits[0] = 1'b1;
          m = m >> 1;
        end
      end
      log2_lut[k] = bits;
    end
    log2_lut[1 << LUT_BITS] = 17'h10000;
  end

  function automatic longint log2_fix(input logic [63:0] x);
    int          e;
    logic [63:0] n, f, idx, r, t0, t1;
    e = 63;
    while (e > 0 && !x[e]) e--;
    n = (e > 30) ? (x >> (e - 30)) : (x << (30 - e));
    f = n & ((64'd1 << 30) - 1);
    idx = f >> LUT_SH;
    r = f & ((64'd1 << LUT_SH) - 1);
    t0 = 64'(log2_lut[idx]);
    t1 = 64'(log2_lut[idx + 1]);
    return longint'((64'(e) << 16) + t0 + (((t1 - t0) * r) >> LUT_SH));
  endfunction

  // floor((p*a + acc*(2^16-a)) / 2^16) with split products
  function automatic logic [63:0] ema_update(input logic [63:0] acc, input logic [63:0] p,
                                             input logic [63:0] a);
    logic [63:0] b, hi, lo, lm;
    b = (64'd1 << 16) - a;
    lm = (64'd1 << 25) - 1;
    hi = (p >> 25) * a + (acc >> 25) * b;
    lo = (p & lm) * a + (acc & lm) * b;
    return (hi << 9) + (lo >> 16);
  endfunction

  function automatic logic [63:0] sq_mag(input longint d);
    logic [63:0] u;
    u = (d < 0) ? 64'(-d) : 64'(d);
    return u * u;
  endfunction

  task automatic predict_sample();
    longint      ri, rq, fi, fq, dl, prod, db;
    logic [63:0] sigp, errp, flr, div, s_new, e_new;
    mer_result_t res;
    ri = longint'(in_rx_i);
    rq = longint'(in_rx_q);
    fi = longint'(in_ref_i);
    fq = longint'(in_ref_q);
    sigp = sq_mag(fi) + sq_mag(fq);
    errp = sq_mag(ri - fi) + sq_mag(rq - fq);
    s_new = ema_update(64'(sig_avg), sigp << 16, 64'(alpha_reg));
    e_new = ema_update(64'(err_avg), errp << 16, 64'(alpha_reg));
    sig_avg = s_new[SACC_W-1:0];
    err_avg = e_new[EACC_W-1:0];
    flr = 64'((floor_reg == 0) ? 16'd1 : floor_reg) << 16;
    div = (64'(err_avg) > flr) ? 64'(err_avg) : flr;
    if (sig_avg == 0) begin
      db = -32768;
    end else begin
      dl = log2_fix(64'(sig_avg)) - log2_fix(div);
      prod = dl * 64'sd197283;
      db = (prod + (64'sd1 <<< 23)) >>> 24;
      if (db > 32767) db = 32767;
      if (db < -32768) db = -32768;
    end
    res.mer = db[15:0];
    res.sig = sig_avg[47:16];
    res.err = err_avg[48:16];
    result_q.push_back(res);
  endtask

  always @(posedge clk) begin
    mer_result_t want;
    if (!rst_n) begin
      alpha_reg <= 16'd656;
      floor_reg <= 16'd1;
      sig_avg = '0;
      err_avg = '0;
      result_q.delete();
    end else begin
      // compare first: a result popped now always belongs to an older item
      if (out_pop && !out_empty) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: result with no item pending: mer %0d sig %0d err %0d",
                     out_mer_db, out_signal_power_avg, out_error_power_avg);
        end else begin
          want = result_q.pop_front();
          if (want.mer !== out_mer_db || want.sig !== out_signal_power_avg ||
              want.err !== out_error_power_avg) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: mer exp %0d got %0d, sig exp %0d got %0d, err exp %0d got %0d",
                       want.mer, out_mer_db, want.sig, out_signal_power_avg,
                       want.err, out_error_power_avg);
          end
        end
      end
      if (in_push && !in_full) predict_sample();
      if (cfg_we) begin
        if (cfg_index == CFG_ALPHA) alpha_reg <= cfg_data;
        else floor_reg <= cfg_data;
      end
    end
    pending <= result_q.size();
  end

endmodule

// ----- verif/tb_modulation_error_ratio_meter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modulation_error_ratio_meter_top
// Drives samples and register writes into the MER meter with random gaps
// and result stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_modulation_error_ratio_meter_top;
  import mer_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic signed [SW-1:0] in_rx_i = '0;
  logic signed [SW-1:0] in_rx_q = '0;
  logic signed [SW-1:0] in_ref_i = '0;
  logic signed [SW-1:0] in_ref_q = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic signed [15:0]   out_mer_db;
  logic [31:0]          out_signal_power_avg;
  logic [32:0]          out_error_power_avg;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_ALPHA;
  logic [CW-1:0]        cfg_data = '0;
  int                   fail_count;
  int                   pending;
  logic                 no_gaps = 1'b0;
  int                   quiet_cycles = 0;

  always #4 clk = ~clk;

  modulation_error_ratio_meter_top u_top (.*);

  mer_checker u_checker (.*);

  // result side: pop at random, always during the no-gap stretch
  always @(posedge clk) begin
    out_pop <= no_gaps || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("modulation_error_ratio_meter_top test failed");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [15:0] rxi, input logic [15:0] rxq,
                             input logic [15:0] rfi, input logic [15:0] rfq);
    while (!no_gaps && $urandom_range(99) < 18) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_i <= rxi;
    in_rx_q <= rxq;
    in_ref_i <= rfi;
    in_ref_q <= rfq;
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // constellation-like symbol plus small noise, now and then fully random
  task automatic send_random();
    logic signed [15:0] rfi, rfq, ni, nq;
    int                 lvl;
    if ($urandom_range(99) < 15) begin
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      lvl = $urandom_range(3);
      rfi = 16'(($urandom_range(3) * 2 - 3) * (2000 << lvl));
      rfq = 16'(($urandom_range(3) * 2 - 3) * (2000 << lvl));
      ni = 16'($signed($urandom_range(1 << $urandom_range(10))) - 16'sd256);
      nq = 16'($signed($urandom_range(1 << $urandom_range(10))) - 16'sd256);
      send_sample(rfi + ni, rfq + nq, rfi, rfq);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero reference, exact match, field extremes at reset weights
    send_sample(16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'h7fff, 16'h8000, 16'd0, 16'd0);
    send_sample(16'd100, 16'd100, 16'd100, 16'd100);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_sample(16'hffff, 16'h0001, 16'h7fff, 16'h7fff);
    drain();

    // full weight, largest floor: averages follow each sample
    write_reg(CFG_ALPHA, 16'hffff);
    write_reg(CFG_FLOOR, 16'hffff);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_sample(16'd1, 16'd0, 16'd1, 16'd0);
    send_sample(16'h8000, 16'h8000, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'd1, 16'd0);
    drain();

    // zero weight holds the averages; zero floor acts as one
    write_reg(CFG_ALPHA, 16'd0);
    write_reg(CFG_FLOOR, 16'd0);
    send_sample(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_sample(16'd5, 16'd5, 16'd5, 16'd5);
    drain();
    write_reg(CFG_ALPHA, 16'd1);
    send_sample(16'd3, 16'd3, 16'd3, 16'd3);
    send_sample(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    drain();

    for (int i = 0; i < 1600; i++) begin
      if (i % 400 == 0) begin
        drain();
        write_reg(CFG_ALPHA, (i == 800) ? 16'hffff : 16'($urandom_range(65535)));
        write_reg(CFG_FLOOR, (i == 1200) ? 16'd0 : 16'($urandom_range(1 << $urandom_range(16)) - 1));
      end
      no_gaps <= (i >= 500 && i < 800);
      send_random();
    end
    no_gaps <= 1'b0;
    drain();
    repeat (100) @(posedge clk);

    if (fail_count == 0)
      $display("modulation_error_ratio_meter_top test passed");
    else
      $display("modulation_error_ratio_meter_top test failed");
    $finish;
  end

endmodule
